FILE: sv/lgfp_pkg.sv
// Shared constants, types and address helpers for the LED grayscale frame packer.
package lgfp_pkg;

  localparam int FRAME_BYTES      = 288;
  localparam int ADDR_W           = $clog2(FRAME_BYTES);
  localparam int ROW_BYTES        = 36;
  localparam int HALF_ROW_BYTES   = 18;
  localparam int LOWER_RIGHT_BASE = 162;
  localparam int LOWER_LEFT_BASE  = 144;
  localparam int COL_W            = $clog2(HALF_ROW_BYTES);

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_SHIFT = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam logic [1:0] COLOUR_RED   = 2'd0;
  localparam logic [1:0] COLOUR_GREEN = 2'd1;
  localparam logic [1:0] COLOUR_BLUE  = 2'd2;
  localparam logic [1:0] COLOUR_NONE  = 2'd3;

  localparam logic [7:0] NIB_HI = 8'hF0;
  localparam logic [7:0] NIB_LO = 8'h0F;

  typedef struct packed {
    logic              we;
    logic              re;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        wdata;
  } mem_req_t;

  // byte that holds the start of an LED's field: led * 9 / 2, rounded down
  function automatic logic [ADDR_W-1:0] led_base(input logic [5:0] led);
    led_base = ADDR_W'({led, 2'b00}) + ADDR_W'(led[5:1]);
  endfunction

  // byte offset of a colour from the LED's base
  function automatic logic [1:0] write_offset(input logic odd, input logic [1:0] colour);
    case (colour)
      COLOUR_RED:   write_offset = 2'd0;
      COLOUR_GREEN: write_offset = odd ? 2'd2 : 2'd1;
      COLOUR_BLUE:  write_offset = 2'd3;
      default:      write_offset = 2'd0;
    endcase
  endfunction

  // high-aligned field: 8 MSBs fill the first byte
  function automatic logic write_hi(input logic odd, input logic [1:0] colour);
    write_hi = odd ^ (colour != COLOUR_GREEN);
  endfunction

  // start of a half row in quadrant order
  function automatic logic [ADDR_W-1:0] row_start(input logic [1:0] quad,
                                                  input logic [1:0] row);
    logic [ADDR_W-1:0] base;
    case (quad)
      2'd0:    base = ADDR_W'(0);
      2'd1:    base = ADDR_W'(HALF_ROW_BYTES);
      2'd2:    base = ADDR_W'(LOWER_RIGHT_BASE);
      default: base = ADDR_W'(LOWER_LEFT_BASE);
    endcase
    row_start = base + ADDR_W'(row * ROW_BYTES);
  endfunction

endpackage

FILE: sv/lgfp_addr_unit.sv
// Shared address adder used by the sequencer for the write and shift accesses to the frame store.
module lgfp_addr_unit import lgfp_pkg::*; (
  input  logic [ADDR_W-1:0] a,
  input  logic [COL_W-1:0]  b,
  output logic [ADDR_W-1:0] sum
);

  assign sum = a + ADDR_W'(b);

endmodule

FILE: sv/lgfp_store.sv
// Single-port frame store with registered read data.
module lgfp_store import lgfp_pkg::*; (
  input  logic       clk,
  input  mem_req_t   req,
  output logic [7:0] rdata
);

  logic [7:0] mem [FRAME_BYTES];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.addr] <= req.wdata;
    end else if (req.re) begin
      rdata <= mem[req.addr];
    end
  end

endmodule

FILE: sv/led_grayscale_frame_packer.sv
// Top level of the LED grayscale frame packer: sequencer, shift counters, output register.
//
// Request channel: req_valid / req_stall with operation, led_number, colour, level.
//   Write places a 12-bit level for one LED and colour; shift emits the next
//   frame byte in quadrant order; clear zeroes the 288-byte store.
// Response channel: rsp_valid / rsp_stall with out_byte and frame_end; one
//   transaction per shift request, frame_end set on the 288th byte.
// Steps per request, set by the single memory port:
//   write: accept plus three accesses (two bytes, one read-modify-write),
//   shift: accept with read, then load of the output register,
//   clear: accept, one zeroing write per byte; ignored codes and colour three: accept.
// req_stall is high while a request is in progress.
// Reset runs the clearing pass with req_stall high; the shift
// position returns to the first byte. A clear leaves the shift position.
// The output register holds a response until it is taken; a shift waits in
// its final step while an earlier response is still stalled.
module led_grayscale_frame_packer import lgfp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  logic [1:0]  operation,
  input  logic [5:0]  led_number,
  input  logic [1:0]  colour,
  input  logic [11:0] level,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output logic [7:0]  out_byte,
  output logic        frame_end
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CLEAR = 3'd1;
  localparam logic [2:0] ST_W0    = 3'd2;
  localparam logic [2:0] ST_W1    = 3'd3;
  localparam logic [2:0] ST_W2    = 3'd4;
  localparam logic [2:0] ST_SHIFT = 3'd5;

  logic [2:0]        state;
  logic [ADDR_W-1:0] sweep;
  logic [ADDR_W-1:0] idx;
  logic              hi;
  logic [11:0]       lvl;
  logic [1:0]        quad;
  logic [1:0]        row;
  logic [COL_W-1:0]  col;
  logic              end_pend;

  logic              accept;
  logic              last;
  logic              load;
  logic [ADDR_W-1:0] add_a;
  logic [COL_W-1:0]  add_b;
  logic [ADDR_W-1:0] add_sum;
  mem_req_t          mem;
  logic [7:0]        rd;

  assign req_stall = (state != ST_IDLE);
  assign accept    = req_valid && !req_stall;
  assign last      = (quad == 2'd3) && (row == 2'd3) && (col == COL_W'(HALF_ROW_BYTES - 1));
  assign load      = (state == ST_SHIFT) && (!rsp_valid || !rsp_stall);

  lgfp_addr_unit u_addr (
    .a   (add_a),
    .b   (add_b),
    .sum (add_sum)
  );

  lgfp_store u_store (
    .clk   (clk),
    .req   (mem),
    .rdata (rd)
  );

  always_comb begin
    add_a = idx;
    add_b = '0;
    case (state)
      ST_IDLE: begin
        if (operation == OP_SHIFT) begin
          add_a = row_start(quad, row);
          add_b = col;
        end else begin
          add_a = led_base(led_number);
          add_b = COL_W'(write_offset(led_number[0], colour));
        end
      end
      ST_W1: add_b = COL_W'(hi);
      ST_W2: add_b = COL_W'(1);
      default: add_b = '0;
    endcase
  end

  always_comb begin
    mem.we    = 1'b0;
    mem.re    = 1'b0;
    mem.addr  = add_sum;
    mem.wdata = '0;
    case (state)
      ST_IDLE: mem.re = accept && (operation == OP_SHIFT);
      ST_CLEAR: begin
        mem.we   = 1'b1;
        mem.addr = sweep;
      end
      ST_W0: begin
        if (hi) begin
          mem.we    = 1'b1;
          mem.wdata = lvl[11:4];
        end else begin
          mem.re = 1'b1;
        end
      end
      ST_W1: begin
        if (hi) begin
          mem.re = 1'b1;
        end else begin
          mem.we    = 1'b1;
          mem.wdata = (rd & NIB_HI) | ({4'h0, lvl[11:8]} & NIB_LO);
        end
      end
      ST_W2: begin
        mem.we    = 1'b1;
        mem.wdata = hi ? (({lvl[3:0], 4'h0} & NIB_HI) | (rd & NIB_LO)) : lvl[7:0];
      end
      default: mem.we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      sweep     <= '0;
      quad      <= '0;
      row       <= '0;
      col       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            case (operation)
              OP_WRITE: begin
                if (colour != COLOUR_NONE) begin
                  state <= ST_W0;
                end
              end
              OP_SHIFT: begin
                state <= ST_SHIFT;
                if (col == COL_W'(HALF_ROW_BYTES - 1)) begin
                  col <= '0;
                  if (row == 2'd3) begin
                    row  <= '0;
                    quad <= quad + 2'd1;
                  end else begin
                    row <= row + 2'd1;
                  end
                end else begin
                  col <= col + COL_W'(1);
                end
              end
              OP_CLEAR: begin
                state <= ST_CLEAR;
                sweep <= '0;
              end
              default: state <= ST_IDLE;
            endcase
          end
        end
        ST_CLEAR: begin
          if (sweep == ADDR_W'(FRAME_BYTES - 1)) begin
            state <= ST_IDLE;
          end
          sweep <= sweep + ADDR_W'(1);
        end
        ST_W0:    state <= ST_W1;
        ST_W1:    state <= ST_W2;
        ST_W2:    state <= ST_IDLE;
        ST_SHIFT: begin
          if (load) begin
            state <= ST_IDLE;
          end
        end
        default:  state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      idx      <= add_sum;
      hi       <= write_hi(led_number[0], colour);
      lvl      <= level;
      end_pend <= last;
    end
    if (load) begin
      out_byte  <= rd;
      frame_end <= end_pend;
    end
  end

  a_end_wraps: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SHIFT && end_pend) |-> (quad == 2'd0 && row == 2'd0 && col == '0))
    else $error("frame end pending but shift position did not wrap");

  a_no_write_in_shift: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SHIFT) |-> !mem.we)
    else $error("frame store written while a shift result is pending");

  a_clear_starts: assert property (@(posedge clk) disable iff (rst)
    (accept && operation == OP_CLEAR) |=> (state == ST_CLEAR && sweep == '0))
    else $error("clear request did not start the sweep at byte zero");

  a_sweep_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |-> (sweep < ADDR_W'(FRAME_BYTES)))
    else $error("clearing sweep ran past the frame store");

endmodule
